// ===== sv/kcl_pkg.sv =====
`timescale 1ns / 1ps

package kcl_pkg;

  // Buffer geometry
  localparam int KCL_BUFFER_SLOTS = 8;
  localparam int KCL_MAX_STORE    = 7;
  localparam int KCL_CODE_LEN     = 6;
  localparam int KCL_CHAR_W       = 8;
  localparam int KCL_CODE_W       = KCL_CODE_LEN * KCL_CHAR_W;
  localparam int KCL_TEXT_W       = KCL_MAX_STORE * KCL_CHAR_W;
  localparam int KCL_LEN_W        = 3;
  localparam int KCL_DELAY_W      = 16;
  localparam int KCL_CFG_IDX_W    = 2;

  // Special characters
  localparam logic [KCL_CHAR_W-1:0] KEY_CLEAR = 8'h43;  // 'C'
  localparam logic [KCL_CHAR_W-1:0] KEY_ENTER = 8'h45;  // 'E'
  localparam logic [KCL_CHAR_W-1:0] CHAR_MANY = 8'h41;  // 'A'
  localparam logic [KCL_CHAR_W-1:0] CHAR_ONE  = 8'h42;  // 'B'

  // Register reset values
  localparam logic [KCL_CODE_W-1:0]  RESET_ARM    = 48'h2A323032352A;  // "*2025*"
  localparam logic [KCL_CODE_W-1:0]  RESET_DISARM = 48'h2B313833302B;  // "+1830+"
  localparam logic [KCL_DELAY_W-1:0] RESET_DELAY  = 16'd7812;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_SENSOR = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_NONE     = 2'd0,
    VERDICT_ARMED    = 2'd1,
    VERDICT_DISARMED = 2'd2,
    VERDICT_FAIL     = 2'd3
  } verdict_e;

  typedef enum logic [KCL_CFG_IDX_W-1:0] {
    CFG_ARM_CODE    = 2'd0,
    CFG_DISARM_CODE = 2'd1,
    CFG_CLEAR_DELAY = 2'd2
  } cfg_idx_e;

endpackage

// ===== sv/kcl_if.sv =====
`timescale 1ns / 1ps

// Input words: key press, sensor sample or timer tick
interface kcl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] key_char;
  logic [3:0] sensor_bits;

  modport source (output valid, op, key_char, sensor_bits, input ready);
  modport sink   (input valid, op, key_char, sensor_bits, output ready);
endinterface

// Result words
interface kcl_out_if;
  logic        valid;
  logic        ready;
  logic        armed;
  logic [1:0]  verdict;
  logic [2:0]  entry_length;
  logic [55:0] entry_text;

  modport source (output valid, armed, verdict, entry_length, entry_text, input ready);
  modport sink   (input valid, armed, verdict, entry_length, entry_text, output ready);
endinterface

// Register writes
interface kcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/keypad_code_lock.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Payload
// in_i     in   valid/ready   op, key_char, sensor_bits
// out_o    out  valid/ready   armed, verdict, entry_length, entry_text
// cfg_i    in   valid/ready   index (0 arm, 1 disarm, 2 delay), data
//
// One word per cycle sustained while results are taken; a word taken into the input register
// passes through the update logic into the result register, from which its result is valid.
// Lock state changes at the same edge the result register loads.
// Reset clears the buffer, the armed flag and the countdown, and loads the default codes.
// A stalled result holds both stages; the input register still takes a word while empty.
// Register writes are always taken (ready held high).

module keypad_code_lock #(
  parameter int BUFFER_SLOTS = kcl_pkg::KCL_BUFFER_SLOTS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kcl_in_if.sink     in_i,
  kcl_out_if.source  out_o,
  kcl_cfg_if.sink    cfg_i
);

  localparam int Cap   = BUFFER_SLOTS - 1;
  localparam int TextW = Cap * kcl_pkg::KCL_CHAR_W;
  localparam int PadW  = kcl_pkg::KCL_TEXT_W - TextW;

  // Registers
  logic [kcl_pkg::KCL_CODE_W-1:0]  arm_code_q, disarm_code_q;
  logic [kcl_pkg::KCL_DELAY_W-1:0] clear_delay_q;

  logic                            in_valid_q;
  logic [1:0]                      op_q;
  logic [kcl_pkg::KCL_CHAR_W-1:0]  key_q;
  logic [3:0]                      sens_q;

  logic [TextW-1:0]                text_q, text_d;
  logic [kcl_pkg::KCL_LEN_W-1:0]   count_q, count_d;
  logic                            armed_q, armed_d;
  logic [kcl_pkg::KCL_DELAY_W-1:0] cnt_q, cnt_d;

  logic                            out_valid_q;
  logic [1:0]                      verdict_q, verdict_d;

  logic advance;
  logic arm_hit, disarm_hit;
  logic [2:0] n_active;
  logic [TextW-1:0] key_shifted;
  logic [TextW-1:0] single_many, single_one;

  // Handshake: input stage moves into the result stage when that one is free
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_code_q    <= kcl_pkg::RESET_ARM;
      disarm_code_q <= kcl_pkg::RESET_DISARM;
      clear_delay_q <= kcl_pkg::RESET_DELAY;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        kcl_pkg::CFG_ARM_CODE:    arm_code_q    <= cfg_i.data;
        kcl_pkg::CFG_DISARM_CODE: disarm_code_q <= cfg_i.data;
        kcl_pkg::CFG_CLEAR_DELAY: clear_delay_q <= cfg_i.data[kcl_pkg::KCL_DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.op;
      key_q  <= in_i.key_char;
      sens_q <= in_i.sensor_bits;
    end
  end

  // Code compare: exactly six characters in the buffer, all bytes equal
  if (Cap >= kcl_pkg::KCL_CODE_LEN) begin : g_match
    assign arm_hit    = (count_q == kcl_pkg::KCL_LEN_W'(kcl_pkg::KCL_CODE_LEN)) &&
                        (text_q[TextW-1 -: kcl_pkg::KCL_CODE_W] == arm_code_q);
    assign disarm_hit = (count_q == kcl_pkg::KCL_LEN_W'(kcl_pkg::KCL_CODE_LEN)) &&
                        (text_q[TextW-1 -: kcl_pkg::KCL_CODE_W] == disarm_code_q);
  end else begin : g_nomatch
    assign arm_hit    = 1'b0;
    assign disarm_hit = 1'b0;
  end

  assign n_active    = 3'($countones(sens_q));
  assign key_shifted = (TextW'(key_q) << (TextW - kcl_pkg::KCL_CHAR_W)) >>
                       {count_q, 3'b000};
  assign single_many = TextW'(kcl_pkg::CHAR_MANY) << (TextW - kcl_pkg::KCL_CHAR_W);
  assign single_one  = TextW'(kcl_pkg::CHAR_ONE) << (TextW - kcl_pkg::KCL_CHAR_W);

  // Lock update for the word in the input register
  always_comb begin
    text_d    = text_q;
    count_d   = count_q;
    armed_d   = armed_q;
    cnt_d     = cnt_q;
    verdict_d = kcl_pkg::VERDICT_NONE;
    unique case (op_q)
      kcl_pkg::OP_KEY: begin
        if (key_q == kcl_pkg::KEY_CLEAR) begin
          text_d  = '0;
          count_d = '0;
        end else if (key_q == kcl_pkg::KEY_ENTER) begin
          if (arm_hit) begin
            armed_d   = 1'b1;
            verdict_d = kcl_pkg::VERDICT_ARMED;
          end else if (disarm_hit) begin
            armed_d   = 1'b0;
            verdict_d = kcl_pkg::VERDICT_DISARMED;
          end else begin
            verdict_d = kcl_pkg::VERDICT_FAIL;
          end
          cnt_d = (clear_delay_q != '0) ? clear_delay_q : kcl_pkg::KCL_DELAY_W'(1);
        end else if (count_q < kcl_pkg::KCL_LEN_W'(Cap)) begin
          text_d  = text_q | key_shifted;
          count_d = count_q + kcl_pkg::KCL_LEN_W'(1);
        end
      end
      kcl_pkg::OP_SENSOR: begin
        if (armed_q && n_active >= 3'd2) begin
          text_d  = single_many;
          count_d = kcl_pkg::KCL_LEN_W'(1);
        end else if (armed_q && n_active == 3'd1) begin
          text_d  = single_one;
          count_d = kcl_pkg::KCL_LEN_W'(1);
        end
      end
      kcl_pkg::OP_TICK: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - kcl_pkg::KCL_DELAY_W'(1);
          if (cnt_q == kcl_pkg::KCL_DELAY_W'(1)) begin
            text_d  = '0;
            count_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Lock state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q      <= '0;
      count_q     <= '0;
      armed_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        text_q  <= text_d;
        count_q <= count_d;
        armed_q <= armed_d;
        cnt_q   <= cnt_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      verdict_q <= verdict_d;
    end
  end

  // The result word shows the lock state left by the last word
  assign out_o.valid        = out_valid_q;
  assign out_o.armed        = armed_q;
  assign out_o.verdict      = verdict_q;
  assign out_o.entry_length = count_q;
  assign out_o.entry_text   = kcl_pkg::KCL_TEXT_W'(text_q) << PadW;

`ifndef SYNTHESIS
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= kcl_pkg::KCL_LEN_W'(Cap))
    else $error("entry length beyond capacity");

  a_empty_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> text_q == '0)
    else $error("empty buffer holds characters");

  a_armed_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && verdict_q == kcl_pkg::VERDICT_ARMED |-> armed_q)
    else $error("armed verdict without armed flag");

  a_disarmed_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && verdict_q == kcl_pkg::VERDICT_DISARMED |-> !armed_q)
    else $error("disarmed verdict with armed flag");

  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed word produced no result");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CAPACITY =
    (kcl_pkg::KCL_BUFFER_SLOTS - 1 > kcl_pkg::KCL_MAX_STORE) ?
    kcl_pkg::KCL_MAX_STORE : kcl_pkg::KCL_BUFFER_SLOTS - 1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] key;
    logic [3:0] sens;
  } lock_word_t;

  typedef struct packed {
    logic        armed;
    logic [1:0]  verdict;
    logic [2:0]  len;
    logic [55:0] text;
  } lock_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  kcl_in_if  in_if ();
  kcl_out_if out_if ();
  kcl_cfg_if cfg_if ();

  keypad_code_lock DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: entry buffer, armed flag, countdown and registers
  logic [55:0] buf_text;
  logic [2:0]  buf_len;
  logic        lock_armed;
  logic [15:0] countdown;
  logic [47:0] arm_code;
  logic [47:0] disarm_code;
  logic [15:0] clear_delay;

  lock_word_t   words_q[$];
  lock_report_t reports_q[$];
  int  words_left = 0;
  int  mismatches = 0;
  bit  steady = 1'b0;

  initial begin
    in_if.valid        = 1'b0;
    in_if.op           = kcl_pkg::OP_KEY;
    in_if.key_char     = '0;
    in_if.sensor_bits  = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = kcl_pkg::CFG_ARM_CODE;
    cfg_if.data        = '0;
    buf_text    = '0;
    buf_len     = '0;
    lock_armed  = 1'b0;
    countdown   = '0;
    arm_code    = kcl_pkg::RESET_ARM;
    disarm_code = kcl_pkg::RESET_DISARM;
    clear_delay = kcl_pkg::RESET_DELAY;
  end

  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < 22);
  endfunction

  // Exact six-character match against the buffer
  function automatic bit code_hit(logic [47:0] code);
    return (buf_len == 3'd6) && (buf_text[55:8] == code);
  endfunction

  // Apply one word to the predicted lock and return the report it produces
  function automatic lock_report_t advance_lock(lock_word_t w);
    lock_report_t r;
    int ones;
    r.verdict = kcl_pkg::VERDICT_NONE;
    case (w.op)
      kcl_pkg::OP_KEY: begin
        if (w.key == kcl_pkg::KEY_CLEAR) begin
          buf_text = '0;
          buf_len  = '0;
        end else if (w.key == kcl_pkg::KEY_ENTER) begin
          if (code_hit(arm_code)) begin
            lock_armed = 1'b1;
            r.verdict  = kcl_pkg::VERDICT_ARMED;
          end else if (code_hit(disarm_code)) begin
            lock_armed = 1'b0;
            r.verdict  = kcl_pkg::VERDICT_DISARMED;
          end else begin
            r.verdict = kcl_pkg::VERDICT_FAIL;
          end
          countdown = (clear_delay == '0) ? 16'd1 : clear_delay;
        end else if (int'(buf_len) < CAPACITY) begin
          buf_text[55 - 8 * int'(buf_len) -: 8] = w.key;
          buf_len = buf_len + 3'd1;
        end
      end
      kcl_pkg::OP_SENSOR: begin
        ones = $countones(w.sens);
        if (lock_armed && ones > 0) begin
          buf_text = {(ones >= 2) ? kcl_pkg::CHAR_MANY : kcl_pkg::CHAR_ONE, 48'h0};
          buf_len  = 3'd1;
        end
      end
      kcl_pkg::OP_TICK: begin
        if (countdown != '0) begin
          countdown = countdown - 16'd1;
          if (countdown == '0) begin
            buf_text = '0;
            buf_len  = '0;
          end
        end
      end
      default: ;
    endcase
    r.armed = lock_armed;
    r.len   = buf_len;
    r.text  = buf_text;
    return r;
  endfunction

  // Input driver: holds a word until taken, idles at random between words
  always @(posedge clk_i) begin : drive_words
    lock_word_t w;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        w = {in_if.op, in_if.key_char, in_if.sensor_bits};
        reports_q.push_back(advance_lock(w));
        words_left = words_left - 1;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (words_q.size() > 0 && !idle_roll()) begin
          w = words_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.op          <= w.op;
          in_if.key_char    <= w.key;
          in_if.sensor_bits <= w.sens;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i) begin : check_reports
    lock_report_t got;
    lock_report_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.armed, out_if.verdict, out_if.entry_length, out_if.entry_text};
        if (reports_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected report: armed=%0d verdict=%0d len=%0d text=%h",
                     got.armed, got.verdict, got.len, got.text);
        end else begin
          want = reports_q.pop_front();
          if (got.armed !== want.armed || got.verdict !== want.verdict ||
              got.len !== want.len || got.text !== want.text) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: exp armed=%0d verdict=%0d len=%0d text=%h",
                       want.armed, want.verdict, want.len, want.text,
                       " / got armed=%0d verdict=%0d len=%0d text=%h",
                       got.armed, got.verdict, got.len, got.text);
          end
        end
      end
      out_if.ready <= !idle_roll();
    end
  end

  task automatic push_word(logic [1:0] op, logic [7:0] key, logic [3:0] sens);
    words_q.push_back('{op: op, key: key, sens: sens});
    words_left = words_left + 1;
  endtask

  task automatic push_key(logic [7:0] key);
    push_word(kcl_pkg::OP_KEY, key, 4'($urandom_range(15)));
  endtask

  task automatic type_code(logic [47:0] code);
    for (int k = 0; k < kcl_pkg::KCL_CODE_LEN; k++)
      push_key(code[47 - 8 * k -: 8]);
  endtask

  // Register write; only issued while the lock has nothing in flight
  task automatic write_reg(kcl_pkg::cfg_idx_e idx, logic [47:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      kcl_pkg::CFG_ARM_CODE:    arm_code    = value;
      kcl_pkg::CFG_DISARM_CODE: disarm_code = value;
      kcl_pkg::CFG_CLEAR_DELAY: clear_delay = value[15:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every word is taken and every report is back
  task automatic drain();
    while (words_left != 0 || reports_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random code without the clear and enter keys, so it can be typed
  function automatic logic [47:0] rand_code();
    logic [47:0] c;
    logic [7:0]  ch;
    for (int k = 0; k < kcl_pkg::KCL_CODE_LEN; k++) begin
      do ch = 8'($urandom_range(255));
      while (ch == kcl_pkg::KEY_CLEAR || ch == kcl_pkg::KEY_ENTER);
      c[47 - 8 * k -: 8] = ch;
    end
    return c;
  endfunction

  // Mostly code entries, with ticks, samples, stray keys and unused ops mixed in
  task automatic random_traffic(int n);
    int pushed;
    int pick;
    int bad;
    int span;
    logic [47:0] code;
    logic [7:0]  ch;
    pushed = 0;
    while (pushed < n) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        code = $urandom_range(1) ? arm_code : disarm_code;
        if ($urandom_range(9) < 7) begin
          push_key(kcl_pkg::KEY_CLEAR);
          pushed++;
        end
        bad = $urandom_range(29);
        for (int k = 0; k < kcl_pkg::KCL_CODE_LEN; k++) begin
          ch = code[47 - 8 * k -: 8];
          if (k == bad) ch = ch ^ 8'($urandom_range(1, 255));
          push_key(ch);
        end
        pushed += kcl_pkg::KCL_CODE_LEN;
        if ($urandom_range(9) == 0) begin
          push_key(8'($urandom_range(255)));
          pushed++;
        end
        push_key(kcl_pkg::KEY_ENTER);
        pushed++;
      end else if (pick < 55) begin
        span = (clear_delay < 16'd12) ? int'(clear_delay) + 2 : 12;
        repeat ($urandom_range(1, span)) begin
          push_word(kcl_pkg::OP_TICK, 8'($urandom_range(255)), 4'($urandom_range(15)));
          pushed++;
        end
      end else if (pick < 70) begin
        push_word(kcl_pkg::OP_SENSOR, 8'($urandom_range(255)), 4'($urandom_range(15)));
        pushed++;
      end else if (pick < 80) begin
        push_key(8'($urandom_range(255)));
        pushed++;
      end else if (pick < 88) begin
        push_key(kcl_pkg::KEY_CLEAR);
        pushed++;
      end else if (pick < 95) begin
        push_key(kcl_pkg::KEY_ENTER);
        pushed++;
      end else begin
        push_word(OP_UNUSED, 8'($urandom_range(255)), 4'($urandom_range(15)));
        pushed++;
      end
    end
  endtask

  // Stimulus phases
  initial begin
    logic [47:0] shared;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: arm, sensor replies, disarm, overflow, failure, idle cases
    push_word(kcl_pkg::OP_TICK, 8'h00, 4'h0);     // tick with no countdown
    type_code(kcl_pkg::RESET_ARM);
    push_key(kcl_pkg::KEY_ENTER);                 // arms
    push_word(kcl_pkg::OP_SENSOR, 8'hFF, 4'b0000); // no sensor active
    push_word(kcl_pkg::OP_SENSOR, 8'h00, 4'b1000); // one sensor
    push_word(kcl_pkg::OP_SENSOR, 8'h00, 4'b0110); // two sensors
    push_key(kcl_pkg::KEY_CLEAR);
    type_code(kcl_pkg::RESET_DISARM);
    push_key(kcl_pkg::KEY_ENTER);                 // disarms
    push_word(kcl_pkg::OP_SENSOR, 8'h00, 4'b1111); // ignored while disarmed
    push_key(8'hFF);                              // fills the buffer
    push_key(8'h00);                              // dropped, buffer full
    push_key(kcl_pkg::KEY_ENTER);                 // seven chars never match
    push_key(kcl_pkg::KEY_CLEAR);
    push_word(kcl_pkg::OP_TICK, 8'h00, 4'hF);     // countdown running
    push_word(OP_UNUSED, 8'hFF, 4'hF);
    drain();

    // Random codes, shortest delay
    write_reg(kcl_pkg::CFG_ARM_CODE, rand_code());
    write_reg(kcl_pkg::CFG_DISARM_CODE, rand_code());
    write_reg(kcl_pkg::CFG_CLEAR_DELAY, 48'd1);
    random_traffic(300);
    drain();

    // All-zero and all-ones codes, zero delay, no idling on either side
    write_reg(kcl_pkg::CFG_ARM_CODE, 48'h0);
    write_reg(kcl_pkg::CFG_DISARM_CODE, 48'hFFFF_FFFF_FFFF);
    write_reg(kcl_pkg::CFG_CLEAR_DELAY, 48'd0);
    steady = 1'b1;
    random_traffic(300);
    drain();
    steady = 1'b0;

    // Same code for both: arming wins; longest delay
    shared = rand_code();
    write_reg(kcl_pkg::CFG_ARM_CODE, shared);
    write_reg(kcl_pkg::CFG_DISARM_CODE, shared);
    write_reg(kcl_pkg::CFG_CLEAR_DELAY, 48'd65535);
    random_traffic(200);
    drain();

    // Random codes, short delay
    write_reg(kcl_pkg::CFG_ARM_CODE, rand_code());
    write_reg(kcl_pkg::CFG_DISARM_CODE, rand_code());
    write_reg(kcl_pkg::CFG_CLEAR_DELAY, 48'($urandom_range(2, 9)));
    random_traffic(400);
    drain();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && reports_q.size() == 0) begin
      $display("[keypad_code_lock] OK");
    end else begin
      $display("[keypad_code_lock] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[keypad_code_lock] ERROR");
    $finish;
  end

endmodule
